@@ sv/text_bounds_measure_defines.svh @@
// Assertion macros for the text bounds measure block.
// No dependencies; included by files that carry concurrent checks.
`ifndef TEXT_BOUNDS_MEASURE_DEFINES_SVH
`define TEXT_BOUNDS_MEASURE_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define TBM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define TBM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/tbm_pkg.sv @@
// Package for the text bounds measure block: screen size, character codes,
// register indexes, request type and span helper. No dependencies.
`default_nettype none

package tbm_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 128;

  localparam logic signed [15:0] MIN_X_INIT = 16'(SCREEN_WIDTH);
  localparam logic signed [15:0] MIN_Y_INIT = 16'(SCREEN_HEIGHT);
  localparam logic signed [15:0] MAX_INIT   = -16'sd1;

  localparam logic [7:0] CODE_NONE    = 8'd0;
  localparam logic [7:0] CODE_NEWLINE = 8'd10;
  localparam logic [7:0] CODE_CR      = 8'd13;

  localparam logic [1:0] REG_FIRST_CODE   = 2'd0;
  localparam logic [1:0] REG_LAST_CODE    = 2'd1;
  localparam logic [1:0] REG_LINE_ADVANCE = 2'd2;
  localparam logic [1:0] REG_WRAP_ENABLE  = 2'd3;

  localparam int ADDR_W = 4;

  typedef struct packed {
    logic              start_req;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic [7:0]        char_code;
    logic [7:0]        glyph_width;
    logic [7:0]        glyph_height;
    logic [7:0]        x_advance;
    logic signed [7:0] x_offset;
    logic signed [7:0] y_offset;
    logic              last;
  } req_t;

  // hi - lo + 1, zero when hi < lo, saturated to 16 bits
  function automatic logic [15:0] span16(logic signed [15:0] lo, logic signed [15:0] hi);
    logic [16:0] d;
    d = {hi[15], hi} - {lo[15], lo};
    if (hi < lo) return 16'd0;
    if (d[15:0] == 16'hFFFF) return 16'hFFFF;
    return d[15:0] + 16'd1;
  endfunction

endpackage

`default_nettype wire

@@ sv/text_bounds_measure.sv @@
// Text bounds measure top level: request register, pen and extreme update,
// result register and APB register file. Uses tbm_pkg and the defines header.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   start, glyph metrics, last
//   out      output     out_valid_o / out_stall_i bound_width, bound_height
//   apb      input      psel, penable, pready     first/last code, advance, wrap
//
// One request per cycle unless in_stall_o; a result passes the request register,
// then the result register. Pen and extreme registers feed their own update.
// Reset clears both valids and the pen, and presets extremes and registers.
// A stalled result holds a request marked last in the request register;
// other requests keep flowing past a stalled result.
`default_nettype none
`include "text_bounds_measure_defines.svh"

module text_bounds_measure (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire                         start_req_i,
  input  wire  signed [15:0]          start_x_i,
  input  wire  signed [15:0]          start_y_i,
  input  wire         [7:0]           char_code_i,
  input  wire         [7:0]           glyph_width_i,
  input  wire         [7:0]           glyph_height_i,
  input  wire         [7:0]           x_advance_i,
  input  wire  signed [7:0]           x_offset_i,
  input  wire  signed [7:0]           y_offset_i,
  input  wire                         last_i,
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output logic        [15:0]          bound_width_o,
  output logic        [15:0]          bound_height_o,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [tbm_pkg::ADDR_W-1:0]  paddr,
  input  wire  [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tbm_pkg::*;

  logic [7:0] first_code_q, last_code_q, line_adv_q;
  logic       wrap_en_q;

  logic req_valid_q, req_valid_d;
  req_t req_q;
  logic req_fire, out_free, in_take;

  logic signed [15:0] pen_x_q, pen_y_q, pen_x_d, pen_y_d;
  logic signed [15:0] min_x_q, min_y_q, max_x_q, max_y_q;
  logic signed [15:0] min_x_d, min_y_d, max_x_d, max_y_d;

  logic out_valid_q, out_valid_d;
  logic [15:0] bw_q, bh_q;

  logic signed [15:0] px_b, py_b, mnx_b, mny_b, mxx_b, mxy_b;
  logic signed [15:0] px_w, py_w, py_adv, x1, y1, x2, y2;
  logic [17:0] reach;
  logic is_glyph, do_wrap;
  logic cfg_wr;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_code_q <= 8'd32;
      last_code_q  <= 8'd126;
      line_adv_q   <= 8'd8;
      wrap_en_q    <= 1'b1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_FIRST_CODE:   first_code_q <= pwdata[7:0];
        REG_LAST_CODE:    last_code_q  <= pwdata[7:0];
        REG_LINE_ADVANCE: line_adv_q   <= pwdata[7:0];
        REG_WRAP_ENABLE:  wrap_en_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FIRST_CODE:   prdata = {24'd0, first_code_q};
      REG_LAST_CODE:    prdata = {24'd0, last_code_q};
      REG_LINE_ADVANCE: prdata = {24'd0, line_adv_q};
      REG_WRAP_ENABLE:  prdata = {31'd0, wrap_en_q};
      default:          prdata = 32'd0;
    endcase
  end

  // request register
  assign out_free   = !out_valid_q || !out_stall_i;
  assign req_fire   = req_valid_q && (!req_q.last || out_free);
  assign in_stall_o = req_valid_q && !req_fire;
  assign in_take    = in_valid_i && !in_stall_o;
  assign req_valid_d = in_take ? 1'b1 : (req_fire ? 1'b0 : req_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_q <= '{start_req_i, start_x_i, start_y_i, char_code_i, glyph_width_i,
                 glyph_height_i, x_advance_i, x_offset_i, y_offset_i, last_i};
    end
  end

  // pen and extreme update
  always_comb begin
    px_b  = req_q.start_req ? req_q.start_x : pen_x_q;
    py_b  = req_q.start_req ? req_q.start_y : pen_y_q;
    mnx_b = req_q.start_req ? MIN_X_INIT : min_x_q;
    mny_b = req_q.start_req ? MIN_Y_INIT : min_y_q;
    mxx_b = req_q.start_req ? MAX_INIT : max_x_q;
    mxy_b = req_q.start_req ? MAX_INIT : max_y_q;

    py_adv   = py_b + {8'd0, line_adv_q};
    is_glyph = (req_q.char_code != CODE_CR) && (req_q.char_code != CODE_NONE) &&
               (req_q.char_code >= first_code_q) && (req_q.char_code <= last_code_q);
    reach    = {{2{px_b[15]}}, px_b} + {{10{req_q.x_offset[7]}}, req_q.x_offset}
             + {10'd0, req_q.glyph_width};
    do_wrap  = wrap_en_q && ($signed(reach) >= $signed(18'(SCREEN_WIDTH)));

    px_w = do_wrap ? 16'sd0 : px_b;
    py_w = do_wrap ? py_adv : py_b;
    x1   = px_w + {{8{req_q.x_offset[7]}}, req_q.x_offset};
    y1   = py_w + {{8{req_q.y_offset[7]}}, req_q.y_offset};
    x2   = x1 + {8'd0, req_q.glyph_width} - 16'd1;
    y2   = y1 + {8'd0, req_q.glyph_height} - 16'd1;

    pen_x_d = px_b;
    pen_y_d = py_b;
    min_x_d = mnx_b;
    min_y_d = mny_b;
    max_x_d = mxx_b;
    max_y_d = mxy_b;
    if (req_q.char_code == CODE_NEWLINE) begin
      pen_x_d = 16'sd0;
      pen_y_d = py_adv;
    end else if (is_glyph) begin
      pen_x_d = px_w + {8'd0, req_q.x_advance};
      pen_y_d = py_w;
      if (x1 < mnx_b) min_x_d = x1;
      if (y1 < mny_b) min_y_d = y1;
      if (x2 > mxx_b) max_x_d = x2;
      if (y2 > mxy_b) max_y_d = y2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q <= 16'sd0;
      pen_y_q <= 16'sd0;
      min_x_q <= MIN_X_INIT;
      min_y_q <= MIN_Y_INIT;
      max_x_q <= MAX_INIT;
      max_y_q <= MAX_INIT;
    end else if (req_fire) begin
      pen_x_q <= pen_x_d;
      pen_y_q <= pen_y_d;
      min_x_q <= min_x_d;
      min_y_q <= min_y_d;
      max_x_q <= max_x_d;
      max_y_q <= max_y_d;
    end
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (req_fire && req_q.last) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire && req_q.last) begin
      bw_q <= span16(min_x_d, max_x_d);
      bh_q <= span16(min_y_d, max_y_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign bound_width_o  = bw_q;
  assign bound_height_o = bh_q;

  `TBM_ASSERT(a_last_gives_result, (req_fire && req_q.last) |=> out_valid_q, "last request lost its result")
  `TBM_ASSERT(a_no_overwrite, (out_valid_q && out_stall_i) |-> !(req_fire && req_q.last), "stalled result overwritten")
  `TBM_ASSERT_ALWAYS(a_min_x_bound, !rst_ni || (min_x_q <= MIN_X_INIT), "min_x above screen width")
  `TBM_ASSERT_ALWAYS(a_max_y_bound, !rst_ni || (max_y_q >= MAX_INIT), "max_y below minus one")

endmodule

`default_nettype wire

@@ tb/text_bounds_checker.sv @@
// Bounds checker for the text bounds measure block: follows the APB writes and
// the request channel, predicts each box and compares the results. Uses tbm_pkg.
`timescale 1ns / 100ps

module text_bounds_checker (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  input  wire                        in_stall_o,
  input  wire                        start_req_i,
  input  wire signed [15:0]          start_x_i,
  input  wire signed [15:0]          start_y_i,
  input  wire        [7:0]           char_code_i,
  input  wire        [7:0]           glyph_width_i,
  input  wire        [7:0]           glyph_height_i,
  input  wire        [7:0]           x_advance_i,
  input  wire signed [7:0]           x_offset_i,
  input  wire signed [7:0]           y_offset_i,
  input  wire                        last_i,
  input  wire                        out_valid_o,
  input  wire                        out_stall_i,
  input  wire        [15:0]          bound_width_o,
  input  wire        [15:0]          bound_height_o,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire [tbm_pkg::ADDR_W-1:0]  paddr,
  input  wire [31:0]                 pwdata,
  input  wire                        pready,
  output int                         fail_count,
  output int                         pending
);
  import tbm_pkg::*;

  typedef struct packed {
    logic [15:0] w;
    logic [15:0] h;
  } box_t;

  box_t box_q[$];

  logic [7:0]         font_first;
  logic [7:0]         font_last;
  logic [7:0]         line_step;
  logic               wrap_on;
  logic signed [15:0] pen_x, pen_y;
  logic signed [15:0] lo_x, lo_y, hi_x, hi_y;

  function automatic logic [15:0] extent(logic signed [15:0] lo, logic signed [15:0] hi);
    int d;
    d = int'(hi) - int'(lo) + 1;
    if (d <= 0) return 16'd0;
    if (d > 65535) return 16'hFFFF;
    return d[15:0];
  endfunction

  task automatic clear_box();
    lo_x = MIN_X_INIT;
    lo_y = MIN_Y_INIT;
    hi_x = MAX_INIT;
    hi_y = MAX_INIT;
  endtask

  task automatic place_char();
    int xo, yo, gw, gh, xa, adv;
    logic signed [15:0] x1, y1, x2, y2;
    xo  = x_offset_i;
    yo  = y_offset_i;
    gw  = glyph_width_i;
    gh  = glyph_height_i;
    xa  = x_advance_i;
    adv = line_step;
    if (start_req_i) begin
      pen_x = start_x_i;
      pen_y = start_y_i;
      clear_box();
    end
    if (char_code_i == CODE_NEWLINE) begin
      pen_x = '0;
      pen_y = 16'(int'(pen_y) + adv);
    end else if (char_code_i != CODE_CR && char_code_i != CODE_NONE &&
                 char_code_i >= font_first && char_code_i <= font_last) begin
      // wrap test uses the exact sum, not the 16-bit one
      if (wrap_on && int'(pen_x) + xo + gw >= SCREEN_WIDTH) begin
        pen_x = '0;
        pen_y = 16'(int'(pen_y) + adv);
      end
      x1 = 16'(int'(pen_x) + xo);
      y1 = 16'(int'(pen_y) + yo);
      x2 = 16'(int'(x1) + gw - 1);
      y2 = 16'(int'(y1) + gh - 1);
      if (x1 < lo_x) lo_x = x1;
      if (y1 < lo_y) lo_y = y1;
      if (x2 > hi_x) hi_x = x2;
      if (y2 > hi_y) hi_y = y2;
      pen_x = 16'(int'(pen_x) + xa);
    end
    if (last_i) box_q.push_back('{extent(lo_x, hi_x), extent(lo_y, hi_y)});
  endtask

  task automatic note_fail(string what, box_t exp_box);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t %s: expected %0d x %0d, got %0d x %0d", $realtime, what,
               exp_box.w, exp_box.h, bound_width_o, bound_height_o);
  endtask

  always @(posedge clk_i) begin
    box_t exp_box;
    if (!rst_ni) begin
      font_first = 8'd32;
      font_last  = 8'd126;
      line_step  = 8'd8;
      wrap_on    = 1'b1;
      pen_x      = '0;
      pen_y      = '0;
      clear_box();
      box_q.delete();
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (box_q.size() == 0) begin
          note_fail("unexpected result", '0);
        end else begin
          exp_box = box_q.pop_front();
          if (bound_width_o !== exp_box.w) note_fail("bound_width mismatch", exp_box);
          if (bound_height_o !== exp_box.h) note_fail("bound_height mismatch", exp_box);
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_FIRST_CODE:   font_first = pwdata[7:0];
          REG_LAST_CODE:    font_last  = pwdata[7:0];
          REG_LINE_ADVANCE: line_step  = pwdata[7:0];
          REG_WRAP_ENABLE:  wrap_on    = pwdata[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) place_char();
    end
    pending = box_q.size();
  end

endmodule

@@ tb/text_bounds_measure_tb.sv @@
// Testbench top for text_bounds_measure: clock, reset, APB setup, request and
// result drivers, verdict. Uses tbm_pkg and text_bounds_checker.
`timescale 1ns / 100ps

module text_bounds_measure_tb;
  import tbm_pkg::*;

  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 300;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                start_req_i;
  logic signed [15:0]  start_x_i;
  logic signed [15:0]  start_y_i;
  logic        [7:0]   char_code_i;
  logic        [7:0]   glyph_width_i;
  logic        [7:0]   glyph_height_i;
  logic        [7:0]   x_advance_i;
  logic signed [7:0]   x_offset_i;
  logic signed [7:0]   y_offset_i;
  logic                last_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic        [15:0]  bound_width_o;
  logic        [15:0]  bound_height_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  int                  fail_count;
  int                  pending;

  bit quiet_tx, quiet_rx, long_hold;
  int font_lo, font_hi;

  text_bounds_measure DUT (.*);

  text_bounds_checker checker_i (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // result side
  initial begin : drain_results
    int unsigned hold;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      hold = quiet_rx ? 0 : $urandom_range(0, 18);
      if (long_hold) begin
        hold = LONG_HOLD;
        long_hold = 1'b0;
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic req_t glyph_req(bit st, int sx, int sy, int code, int gw, int gh,
                                     int xa, int xo, int yo, bit lst);
    req_t r;
    r.start_req    = st;
    r.start_x      = 16'(sx);
    r.start_y      = 16'(sy);
    r.char_code    = 8'(code);
    r.glyph_width  = 8'(gw);
    r.glyph_height = 8'(gh);
    r.x_advance    = 8'(xa);
    r.x_offset     = 8'(xo);
    r.y_offset     = 8'(yo);
    r.last         = lst;
    return r;
  endfunction

  function automatic req_t noise_req();
    return glyph_req($urandom_range(0, 1), $urandom, $urandom, $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom, $urandom, $urandom_range(0, 1));
  endfunction

  function automatic req_t text_req(bit head, bit tail);
    req_t r;
    int pick;
    r = glyph_req(head ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 19) == 0),
                  int'($urandom_range(0, 160)) - 20, int'($urandom_range(0, 160)) - 20,
                  0, $urandom_range(0, 16), $urandom_range(0, 16), $urandom_range(0, 16),
                  int'($urandom_range(0, 8)) - 4, int'($urandom_range(0, 16)) - 8, tail);
    if ($urandom_range(0, 7) == 0) begin
      r.start_x = 16'($urandom);
      r.start_y = 16'($urandom);
    end
    if ($urandom_range(0, 9) == 0) begin
      r.glyph_width  = 8'($urandom);
      r.glyph_height = 8'($urandom);
      r.x_advance    = 8'($urandom);
      r.x_offset     = 8'($urandom);
      r.y_offset     = 8'($urandom);
    end
    pick = $urandom_range(0, 19);
    if (pick == 0)
      r.char_code = CODE_NEWLINE;
    else if (pick == 1)
      r.char_code = CODE_CR;
    else if (pick == 2)
      r.char_code = CODE_NONE;
    else if (pick == 3 || font_lo > font_hi)
      r.char_code = 8'($urandom_range(0, 255));
    else
      r.char_code = 8'($urandom_range(font_lo, font_hi));
    return r;
  endfunction

  task automatic push_char(input req_t r);
    int unsigned gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 18);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_req_i    <= r.start_req;
    start_x_i      <= r.start_x;
    start_y_i      <= r.start_y;
    char_code_i    <= r.char_code;
    glyph_width_i  <= r.glyph_width;
    glyph_height_i <= r.glyph_height;
    x_advance_i    <= r.x_advance;
    x_offset_i     <= r.x_offset;
    y_offset_i     <= r.y_offset;
    last_i         <= r.last;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input int lo, input int hi, input int adv, input int wrap);
    settle();
    write_reg(REG_FIRST_CODE, 32'(lo));
    write_reg(REG_LAST_CODE, 32'(hi));
    write_reg(REG_LINE_ADVANCE, 32'(adv));
    write_reg(REG_WRAP_ENABLE, 32'(wrap));
    font_lo = lo;
    font_hi = hi;
  endtask

  task automatic random_phase(input int n_items);
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        push_char(noise_req());
        sent++;
      end else begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) push_char(text_req(i == 0, i == len - 1));
        sent += len;
      end
    end
  endtask

  // result side holds off while short strings keep arriving
  task automatic stall_burst();
    long_hold = 1'b1;
    quiet_tx  = 1'b1;
    for (int i = 0; i < 40; i++) push_char(text_req(1'b1, $urandom_range(0, 1)));
    quiet_tx  = 1'b0;
  endtask

  initial begin : stimulus
    int guard;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    start_req_i    = 1'b0;
    start_x_i      = '0;
    start_y_i      = '0;
    char_code_i    = '0;
    glyph_width_i  = '0;
    glyph_height_i = '0;
    x_advance_i    = '0;
    x_offset_i     = '0;
    y_offset_i     = '0;
    last_i         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    quiet_tx       = 1'b0;
    quiet_rx       = 1'b0;
    long_hold      = 1'b0;
    font_lo        = 32;
    font_hi        = 126;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset font settings
    push_char(glyph_req(1, 0, 0, 65, 5, 7, 6, 0, 0, 0));
    push_char(glyph_req(0, 0, 0, 66, 5, 7, 6, 0, -1, 1));
    push_char(glyph_req(1, 10, 20, CODE_NEWLINE, 0, 0, 0, 0, 0, 0));
    push_char(glyph_req(0, 0, 0, 72, 8, 8, 8, 2, -3, 0));
    push_char(glyph_req(0, 0, 0, CODE_CR, 9, 9, 9, 0, 0, 0));
    push_char(glyph_req(0, 0, 0, CODE_NONE, 9, 9, 9, 0, 0, 0));
    push_char(glyph_req(0, 0, 0, 200, 9, 9, 9, 0, 0, 0));
    push_char(glyph_req(0, 0, 0, 31, 9, 9, 9, 0, 0, 0));
    push_char(glyph_req(0, 0, 0, 126, 4, 4, 4, 0, 0, 1));
    push_char(glyph_req(1, 5, 5, 33, 0, 0, 4, 0, 0, 1));
    push_char(glyph_req(1, 0, 0, CODE_NONE, 0, 0, 0, 0, 0, 1));
    push_char(glyph_req(1, 120, 0, 65, 10, 8, 10, 0, 0, 0));
    push_char(glyph_req(0, 0, 0, 32, 10, 8, 10, 0, 0, 1));
    push_char(glyph_req(1, 32767, -32768, 32, 255, 255, 255, -128, -128, 0));
    push_char(glyph_req(0, 0, 0, 126, 255, 255, 255, 127, 127, 1));
    push_char(glyph_req(0, 0, 0, 65, 3, 3, 3, 0, 0, 1));
    push_char(glyph_req(1, -32768, 32767, 50, 255, 255, 255, 127, 127, 1));
    push_char(glyph_req(1, 200, 200, 65, 4, 4, 4, 0, 0, 1));
    push_char(glyph_req(1, -50, -50, 65, 4, 4, 4, 0, 0, 1));

    // full font, no wrap: box spanning the whole 16-bit range
    configure(0, 255, 255, 0);
    push_char(glyph_req(1, 32640, 32767, 65, 1, 1, 255, 127, 0, 0));
    push_char(glyph_req(0, 0, 0, 66, 1, 1, 0, -127, 1, 1));
    push_char(glyph_req(1, 0, 0, CODE_NEWLINE, 0, 0, 0, 0, 0, 0));
    push_char(glyph_req(0, 0, 0, CODE_NONE, 5, 5, 5, 0, 0, 0));
    push_char(glyph_req(0, 0, 0, CODE_CR, 5, 5, 5, 0, 0, 0));
    push_char(glyph_req(0, 0, 0, 255, 5, 5, 5, 0, 0, 1));

    // empty font range
    configure(100, 50, 0, 1);
    push_char(glyph_req(1, 0, 0, 75, 5, 5, 5, 0, 0, 0));
    push_char(glyph_req(0, 0, 0, CODE_NEWLINE, 5, 5, 5, 0, 0, 1));

    configure(255, 255, 1, 1);
    push_char(glyph_req(1, 126, 0, 255, 4, 4, 4, 0, 0, 1));

    configure(32, 126, 8, 1);
    quiet_tx = 1'b1;
    quiet_rx = 1'b1;
    random_phase(150);
    quiet_tx = 1'b0;
    quiet_rx = 1'b0;
    stall_burst();

    configure(0, 255, 0, 1);
    quiet_rx = 1'b1;
    random_phase(150);
    quiet_rx = 1'b0;

    configure($urandom_range(0, 40), $urandom_range(90, 255), $urandom_range(1, 255),
              $urandom_range(0, 1));
    random_phase(150);

    configure(1, 254, 255, 0);
    quiet_tx = 1'b1;
    random_phase(150);
    quiet_tx = 1'b0;
    stall_burst();

    configure(48, 90, $urandom_range(0, 20), 1);
    random_phase(150);

    configure(120, 20, 16, 0);
    random_phase(100);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    guard = 0;
    while (pending != 0 && guard < 20000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
